/* design/lpf_pkg.sv */
// Package for the length-prefixed packet FIFO: sizes, status codes and ring index helper.
// No dependencies; used by length_prefixed_packet_fifo_unit.
package lpf_pkg;

    localparam int RING_DEPTH = 128;
    localparam int MAX_PACKET = 64;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OLEN_W   = 7;

    localparam logic [STATUS_W-1:0] ST_DATA   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

/* design/lpf_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/length_prefixed_packet_fifo_unit.sv */
// Top level of the length-prefixed packet FIFO: control, pointers and result register.
// Depends on lpf_pkg and lpf_ram.

// Packets are kept in a RING_DEPTH-byte ring as a length byte followed by the payload.
// Input beats are taken one at a time: a payload byte of an open packet, a stray byte,
// a rejected first byte, a busy or an empty pop are handled in S_IDLE alone; the first
// byte of an accepted packet goes through S_IDLE, then S_PUSH2, because the length byte
// and the payload byte share the ring's single write port. A pop reads the length byte
// in S_IDLE, clamps it in S_LEN, then returns one payload beat per cycle in S_DATA
// while the result side does not stall. A new input beat is taken only in S_IDLE and
// when the result register is empty or being emptied in the same cycle. The ring needs
// no clearing pass after reset; only committed entries are ever read.
module length_prefixed_packet_fifo_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] packet_length
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [14:8] out_length, [15] not_empty
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last_of_packet
);
    import lpf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PUSH2 = 2'd1;
    localparam logic [1:0] S_LEN   = 2'd2;
    localparam logic [1:0] S_DATA  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    stored_reg, stored_next;
    logic [BYTE_W-1:0]   push_left_reg, push_left_next;
    logic [BYTE_W-1:0]   open_len_reg, open_len_next;
    logic [BYTE_W-1:0]   hold_byte_reg, hold_byte_next;
    logic [BYTE_W-1:0]   pop_len_reg, pop_len_next;
    logic [BYTE_W-1:0]   pop_left_reg, pop_left_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [OLEN_W-1:0]   out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;
    logic                out_ne_reg, out_ne_next;

    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [BYTE_W-1:0]   ram_wdata, ram_rdata;

    logic                out_free, in_beat;
    logic                in_cmd, in_first;
    logic [BYTE_W-1:0]   in_byte, in_len;
    logic [CMP_W-1:0]    free_bytes, need_bytes, avail_payload;
    logic [BYTE_W-1:0]   plen_eff;
    logic [CNT_W-1:0]    stored_plus;

    lpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_beat  = s_tvalid && s_tready;

    assign in_byte  = s_tdata[7:0];
    assign in_len   = s_tdata[15:8];
    assign in_cmd   = s_tuser[0];
    assign in_first = s_tuser[1];

    assign free_bytes    = CMP_W'(RING_DEPTH) - CMP_W'(stored_reg);
    assign need_bytes    = CMP_W'(in_len) + 1'b1;
    assign avail_payload = CMP_W'(stored_reg) - 1'b1;
    // clamp the length to what is committed behind the length byte
    assign plen_eff      = (CMP_W'(ram_rdata) > avail_payload) ?
                           BYTE_W'(avail_payload) : ram_rdata;
    assign stored_plus   = stored_reg + CNT_W'(open_len_reg) + 1'b1;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        stored_next     = stored_reg;
        push_left_next  = push_left_reg;
        open_len_next   = open_len_reg;
        hold_byte_next  = hold_byte_reg;
        pop_len_next    = pop_len_reg;
        pop_left_next   = pop_left_reg;

        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        out_ne_next     = out_ne_reg;

        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = in_byte;
        ram_re    = 1'b0;
        ram_raddr = tail_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    out_byte_next = '0;
                    out_len_next  = '0;
                    out_last_next = 1'b0;
                    if (in_cmd == CMD_POP) begin
                        if (push_left_reg != '0) begin
                            m_tvalid_next   = 1'b1;
                            out_status_next = ST_BUSY;
                            out_ne_next     = (stored_reg != '0);
                        end else if (stored_reg == '0) begin
                            m_tvalid_next   = 1'b1;
                            out_status_next = ST_EMPTY;
                            out_ne_next     = 1'b0;
                        end else begin
                            ram_re     = 1'b1;
                            tail_next  = ring_adv(tail_reg);
                            state_next = S_LEN;
                        end
                    end else if (push_left_reg != '0) begin
                        ram_we         = 1'b1;
                        head_next      = ring_adv(head_reg);
                        push_left_next = push_left_reg - 1'b1;
                        if (push_left_reg == BYTE_W'(1)) begin
                            stored_next     = stored_plus;
                            m_tvalid_next   = 1'b1;
                            out_status_next = ST_ACCEPT;
                            out_ne_next     = 1'b1;
                        end
                    end else if (in_first) begin
                        if (in_len == '0 || in_len > BYTE_W'(MAX_PACKET) ||
                            free_bytes < need_bytes) begin
                            m_tvalid_next   = 1'b1;
                            out_status_next = ST_REJECT;
                            out_ne_next     = (stored_reg != '0);
                        end else begin
                            // length byte now, payload byte next cycle
                            ram_we         = 1'b1;
                            ram_wdata      = in_len;
                            head_next      = ring_adv(head_reg);
                            open_len_next  = in_len;
                            hold_byte_next = in_byte;
                            state_next     = S_PUSH2;
                        end
                    end
                end
            end
            S_PUSH2: begin
                ram_we         = 1'b1;
                ram_wdata      = hold_byte_reg;
                head_next      = ring_adv(head_reg);
                push_left_next = open_len_reg - 1'b1;
                state_next     = S_IDLE;
                if (open_len_reg == BYTE_W'(1)) begin
                    stored_next     = stored_plus;
                    m_tvalid_next   = 1'b1;
                    out_status_next = ST_ACCEPT;
                    out_byte_next   = '0;
                    out_len_next    = '0;
                    out_last_next   = 1'b0;
                    out_ne_next     = 1'b1;
                end
            end
            S_LEN: begin
                // take the whole packet off the count now
                stored_next = stored_reg - 1'b1 - CNT_W'(plen_eff);
                if (plen_eff == '0) begin
                    state_next = S_IDLE;
                end else begin
                    ram_re        = 1'b1;
                    tail_next     = ring_adv(tail_reg);
                    pop_len_next  = plen_eff;
                    pop_left_next = plen_eff;
                    state_next    = S_DATA;
                end
            end
            S_DATA: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = ST_DATA;
                    out_byte_next   = ram_rdata;
                    out_len_next    = pop_len_reg[OLEN_W-1:0];
                    out_last_next   = (pop_left_reg == BYTE_W'(1));
                    out_ne_next     = (stored_reg != '0);
                    pop_left_next   = pop_left_reg - 1'b1;
                    if (pop_left_reg == BYTE_W'(1)) begin
                        state_next = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        tail_next = ring_adv(tail_reg);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            stored_reg    <= '0;
            push_left_reg <= '0;
            open_len_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            stored_reg    <= stored_next;
            push_left_reg <= push_left_next;
            open_len_reg  <= open_len_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_byte_reg  <= hold_byte_next;
        pop_len_reg    <= pop_len_next;
        pop_left_reg   <= pop_left_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
        out_ne_reg     <= out_ne_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_ne_reg, out_len_reg, out_byte_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_stored_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_reg <= CNT_W'(RING_DEPTH))
        else $error("committed byte count exceeds ring depth");

    a_no_pop_during_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LEN || state_reg == S_DATA) |-> push_left_reg == '0)
        else $error("pop in progress while a packet is open");

    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DATA |-> pop_left_reg != '0)
        else $error("payload stream with no bytes left");

    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == ST_DATA && m_tdata[15] == (stored_reg != '0)))
        else $error("last beat not a data beat or wrong non-empty flag");

    a_len_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) == S_IDLE && state_reg == S_LEN |-> $past(stored_reg) != '0)
        else $error("length read from an empty ring");

endmodule

/* bench/length_prefixed_packet_fifo_unit_tb.sv */
// Self-checking bench for length_prefixed_packet_fifo_unit: a directed table, then random
// packet traffic with stalls on both sides, checked beat by beat against a packet ring model.
// Depends on lpf_pkg and the design sources.
module length_prefixed_packet_fifo_unit_tb;
    import lpf_pkg::*;

    localparam int RANDOM_ITEMS = 260;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic [6:0] out_len;
        logic       last;
        logic       not_empty;
    } fifo_result_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic [7:0] len;
        logic       first;
        logic       typed;
        logic [2:0] t_status;
        logic       t_not_empty;
    } stim_row_t;

    // Rows with typed set carry their result here; the rest go through the ring model.
    stim_row_t directed_rows [17] = '{
        '{CMD_POP,  8'h00, 8'd0,   1'b0, 1'b1, ST_EMPTY,  1'b0}, // pop on empty ring
        '{CMD_PUSH, 8'h3C, 8'd5,   1'b0, 1'b0, ST_DATA,   1'b0}, // stray byte
        '{CMD_PUSH, 8'hFF, 8'd0,   1'b1, 1'b1, ST_REJECT, 1'b0}, // zero length
        '{CMD_PUSH, 8'h00, 8'd65,  1'b1, 1'b1, ST_REJECT, 1'b0}, // one above max
        '{CMD_PUSH, 8'hFF, 8'd255, 1'b1, 1'b1, ST_REJECT, 1'b0}, // largest length field
        '{CMD_PUSH, 8'h00, 8'd0,   1'b0, 1'b0, ST_DATA,   1'b0}, // tail of rejected packet
        '{CMD_PUSH, 8'hFF, 8'd1,   1'b1, 1'b1, ST_ACCEPT, 1'b1}, // single-byte packet
        '{CMD_PUSH, 8'h00, 8'd3,   1'b1, 1'b0, ST_DATA,   1'b0}, // open a 3-byte packet
        '{CMD_POP,  8'hFF, 8'd255, 1'b1, 1'b1, ST_BUSY,   1'b1}, // pop while push open
        '{CMD_PUSH, 8'hA5, 8'd0,   1'b1, 1'b0, ST_DATA,   1'b0}, // first mark inside packet
        '{CMD_PUSH, 8'h5A, 8'd255, 1'b0, 1'b0, ST_DATA,   1'b0}, // final byte
        '{CMD_POP,  8'h00, 8'd0,   1'b0, 1'b0, ST_DATA,   1'b0},
        '{CMD_POP,  8'h00, 8'd0,   1'b0, 1'b0, ST_DATA,   1'b0},
        '{CMD_POP,  8'h00, 8'd0,   1'b0, 1'b1, ST_EMPTY,  1'b0},
        '{CMD_PUSH, 8'h7E, 8'd2,   1'b1, 1'b0, ST_DATA,   1'b0},
        '{CMD_PUSH, 8'h81, 8'd64,  1'b0, 1'b0, ST_DATA,   1'b0},
        '{CMD_POP,  8'h00, 8'd0,   1'b0, 1'b0, ST_DATA,   1'b0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Ring model state
    logic [7:0] ring_mem [RING_DEPTH];
    int wr_ptr      = 0;
    int rd_ptr      = 0;
    int used_bytes  = 0;
    int bytes_to_go = 0;
    int open_len    = 0;

    fifo_result_t step_results[$];
    fifo_result_t awaited_results[$];
    int errors     = 0;
    int items_sent = 0;
    int stall_left = 0;
    bit quiet      = 1'b0;

    length_prefixed_packet_fifo_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic fifo_result_t make_result(input logic [2:0] st, input logic [7:0] b,
                                                 input logic [6:0] l, input logic last);
        fifo_result_t r;
        r.status    = st;
        r.out_byte  = b;
        r.out_len   = l;
        r.last      = last;
        r.not_empty = 1'b0;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 20);
    endfunction

    // Advance the ring model by one input beat; leave its results in step_results.
    task automatic packet_fifo_step(input logic cmd, input logic [7:0] b,
                                    input logic [7:0] len, input logic first);
        int plen;
        step_results.delete();
        if (cmd == CMD_POP) begin
            if (bytes_to_go != 0) begin
                step_results.push_back(make_result(ST_BUSY, 8'h00, 7'd0, 1'b0));
            end else if (used_bytes == 0) begin
                step_results.push_back(make_result(ST_EMPTY, 8'h00, 7'd0, 1'b0));
            end else begin
                plen = int'(ring_mem[rd_ptr]);
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                used_bytes--;
                if (plen > used_bytes)
                    plen = used_bytes;
                for (int i = 0; i < plen; i++) begin
                    step_results.push_back(make_result(ST_DATA, ring_mem[rd_ptr],
                                                       7'(plen), i == plen - 1));
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    used_bytes--;
                end
            end
        end else if (bytes_to_go != 0) begin
            ring_mem[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            bytes_to_go--;
            if (bytes_to_go == 0) begin
                used_bytes += open_len + 1;
                step_results.push_back(make_result(ST_ACCEPT, 8'h00, 7'd0, 1'b0));
            end
        end else if (first) begin
            if (len == 0 || len > MAX_PACKET || RING_DEPTH - used_bytes < int'(len) + 1) begin
                step_results.push_back(make_result(ST_REJECT, 8'h00, 7'd0, 1'b0));
            end else begin
                open_len = int'(len);
                ring_mem[wr_ptr] = len;
                wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                ring_mem[wr_ptr] = b;
                wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                bytes_to_go = int'(len) - 1;
                if (bytes_to_go == 0) begin
                    used_bytes += open_len + 1;
                    step_results.push_back(make_result(ST_ACCEPT, 8'h00, 7'd0, 1'b0));
                end
            end
        end
        foreach (step_results[k])
            step_results[k].not_empty = (used_bytes != 0);
    endtask

    // Offer one beat after a random gap, hold it until taken, then predict its results.
    task automatic send_beat(input logic cmd, input logic [7:0] b, input logic [7:0] len,
                             input logic first, input bit keep_prediction);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, b};
        s_tuser  <= {first, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        packet_fifo_step(cmd, b, len, first);
        if (keep_prediction)
            foreach (step_results[k])
                awaited_results.push_back(step_results[k]);
    endtask

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(1, 6));
        else if (r < 90)
            return 8'($urandom_range(7, MAX_PACKET - 1));
        else
            return 8'(MAX_PACKET);
    endfunction

    // Push a well-formed packet; sprinkle first marks inside it and maybe a busy pop.
    task automatic push_packet(input logic [7:0] plen, input bit with_pop);
        int pop_at;
        pop_at = (with_pop && plen > 1) ? $urandom_range(1, plen - 1) : -1;
        send_beat(CMD_PUSH, 8'($urandom), plen, 1'b1, 1'b1);
        for (int i = 1; i < plen; i++) begin
            if (i == pop_at)
                send_beat(CMD_POP, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                          1'b1);
            send_beat(CMD_PUSH, 8'($urandom), 8'($urandom),
                      (bytes_to_go != 0) && ($urandom_range(0, 9) == 0), 1'b1);
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side stalls
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Alternate stretches with and without idling
    always begin
        repeat ($urandom_range(100, 400)) @(posedge aclk);
        quiet <= ~quiet;
    end

    always @(posedge aclk) begin : result_check
        fifo_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected beat, status %0d byte %0d", $time, m_tuser,
                         m_tdata[7:0]);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", int'(want.status), int'(m_tuser));
                check_field("out_byte", int'(want.out_byte), int'(m_tdata[7:0]));
                check_field("out_length", int'(want.out_len), int'(m_tdata[14:8]));
                check_field("last", int'(want.last), int'(m_tlast));
                check_field("not_empty", int'(want.not_empty), int'(m_tdata[15]));
            end
        end
    end

    initial begin
        #8000000;
        $display("length_prefixed_packet_fifo_unit_tb failed");
        $finish;
    end

    initial begin
        fifo_result_t typed_res;
        int op;
        int ops_in_phase;
        bit filling;
        ops_in_phase = 0;
        filling = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].len,
                      directed_rows[i].first, !directed_rows[i].typed);
            if (directed_rows[i].typed) begin
                typed_res = make_result(directed_rows[i].t_status, 8'h00, 7'd0, 1'b0);
                typed_res.not_empty = directed_rows[i].t_not_empty;
                awaited_results.push_back(typed_res);
            end
        end

        // Alternate fill-heavy and drain-heavy phases so the ring runs full and empty.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            ops_in_phase++;
            if (ops_in_phase == 25) begin
                ops_in_phase = 0;
                filling = !filling;
            end
            op = $urandom_range(0, 99);
            if (op < (filling ? 15 : 55)) begin
                send_beat(CMD_POP, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                          1'b1);
            end else if (op < (filling ? 25 : 63)) begin
                send_beat(CMD_PUSH, 8'($urandom),
                          ($urandom_range(0, 3) == 0) ? 8'd0
                                                      : 8'($urandom_range(MAX_PACKET + 1, 255)),
                          1'b1, 1'b1);
                repeat ($urandom_range(0, 2))
                    send_beat(CMD_PUSH, 8'($urandom), 8'($urandom), 1'b0, 1'b1);
            end else if (op < (filling ? 29 : 67)) begin
                send_beat(CMD_PUSH, 8'($urandom), 8'($urandom), 1'b0, 1'b1);
            end else begin
                push_packet(pick_len(), $urandom_range(0, 9) == 0);
            end
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("length_prefixed_packet_fifo_unit_tb passed");
        else
            $display("length_prefixed_packet_fifo_unit_tb failed");
        $finish;
    end

endmodule

/* filelist.f */
design/lpf_pkg.sv
design/lpf_ram.sv
design/length_prefixed_packet_fifo_unit.sv
bench/length_prefixed_packet_fifo_unit_tb.sv
